// ===== hw/rtl/dvg_pkg.sv =====
// shared types and constants for the utilization dvfs governor
// used by dvg_core, the top level and the checker; no dependencies
`default_nettype none

package dvg_pkg;

   localparam int UTIL_WIDTH = 9;
   localparam logic [UTIL_WIDTH-1:0] UTIL_FULL = 9'd256;

   localparam int CSR_INDEX_WIDTH = 3;
   localparam int CSR_DATA_WIDTH  = 16;

   // register indexes of the csr port
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_UP_TO_HIGH1   = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_UP_TO_HIGH2   = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_DOWN_TO_LOW   = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_DOWN_TO_HIGH1 = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_STEP_DELAY    = 3'd4;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_FORCE_ENABLE  = 3'd5;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_FORCE_THRESH  = 3'd6;

   // reset values of the thresholds
   localparam logic [UTIL_WIDTH-1:0] RST_UP_TO_HIGH1   = 9'd192;
   localparam logic [UTIL_WIDTH-1:0] RST_UP_TO_HIGH2   = 9'd235;
   localparam logic [UTIL_WIDTH-1:0] RST_DOWN_TO_LOW   = 9'd96;
   localparam logic [UTIL_WIDTH-1:0] RST_DOWN_TO_HIGH1 = 9'd64;
   localparam logic [UTIL_WIDTH-1:0] RST_FORCE_THRESH  = UTIL_FULL - 9'd5;
   localparam logic [CSR_DATA_WIDTH-1:0] RST_STEP_DELAY = 16'd300;

   // item opcodes
   localparam logic OP_SAMPLE = 1'b0;
   localparam logic OP_TICK   = 1'b1;

   // performance levels
   localparam logic [1:0] LEVEL_LOW   = 2'd0;
   localparam logic [1:0] LEVEL_HIGH1 = 2'd1;
   localparam logic [1:0] LEVEL_HIGH2 = 2'd2;

   typedef struct packed {
      logic [UTIL_WIDTH-1:0] up_to_high1;
      logic [UTIL_WIDTH-1:0] up_to_high2;
      logic [UTIL_WIDTH-1:0] down_to_low;
      logic [UTIL_WIDTH-1:0] down_to_high1;
      logic                  force_enable;
      logic [UTIL_WIDTH-1:0] force_thresh;
   } cfg_type;

   // governor state apart from the delay counter
   typedef struct packed {
      logic [1:0] level;
      logic       force_flag;
      logic       up_pending;
      logic       down_pending;
      logic       domain_req;
      logic       bus_req;
   } state_type;

   typedef struct packed {
      logic [1:0] level;
      logic       domain_max_request;
      logic       bus_max_request;
      logic       cpu_forced_max;
      logic       level_changed;
      logic       cpu_released;
   } result_type;

   function automatic logic [UTIL_WIDTH-1:0] sat_util(input logic [UTIL_WIDTH-1:0] v);
      return (v > UTIL_FULL) ? UTIL_FULL : v;
   endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/dvg_core.sv =====
// next-state and result logic of the governor for one beat
// depends on dvg_pkg
`default_nettype none

module dvg_core #(
   parameter int DELAY_WIDTH = 16
) (
   input  var dvg_pkg::state_type  state,
   input  var logic [DELAY_WIDTH-1:0] count,
   input  var dvg_pkg::cfg_type    cfg,
   input  var logic [DELAY_WIDTH-1:0] step_delay,
   input  var logic                opcode,
   input  var logic [dvg_pkg::UTIL_WIDTH-1:0] utilization,
   output dvg_pkg::state_type      state_nxt,
   output logic [DELAY_WIDTH-1:0]  count_nxt,
   output dvg_pkg::result_type     result
);
   import dvg_pkg::*;

   logic [UTIL_WIDTH-1:0] util_sat;
   logic                  up_hit;
   logic                  down_hit;
   logic                  changed;
   logic                  released;

   always_comb begin
      util_sat  = sat_util(utilization);
      up_hit    = ((state.level == LEVEL_HIGH1) && (util_sat > sat_util(cfg.up_to_high2))) ||
                  ((state.level == LEVEL_LOW) && (util_sat > sat_util(cfg.up_to_high1)));
      down_hit  = ((state.level == LEVEL_HIGH1) && (util_sat < sat_util(cfg.down_to_low))) ||
                  ((state.level == LEVEL_HIGH2) && (util_sat < sat_util(cfg.down_to_high1)));
      state_nxt = state;
      count_nxt = count;
      changed   = 1'b0;
      released  = 1'b0;

      if (opcode == OP_SAMPLE) begin
         state_nxt.domain_req = (state.level != LEVEL_LOW);
         state_nxt.bus_req    = (state.level == LEVEL_HIGH2);
         if ((state.level == LEVEL_HIGH2) && cfg.force_enable &&
             (util_sat >= sat_util(cfg.force_thresh))) begin
            state_nxt.force_flag = 1'b1;
         end
         // up check first, then down check may override it
         if (up_hit) begin
            state_nxt.down_pending = 1'b0;
            if (!state.up_pending) begin
               state_nxt.up_pending = 1'b1;
               count_nxt            = step_delay;
            end
         end
         if (down_hit) begin
            state_nxt.up_pending = 1'b0;
            if (!state_nxt.down_pending) begin
               state_nxt.down_pending = 1'b1;
               count_nxt              = step_delay;
            end
         end
      end else if (state.up_pending || state.down_pending) begin
         if (count > DELAY_WIDTH'(1)) begin
            count_nxt = count - DELAY_WIDTH'(1);
         end else begin
            count_nxt            = '0;
            released             = state.force_flag;
            state_nxt.force_flag = 1'b0;
            if (state.up_pending) begin
               if (state.level != LEVEL_HIGH2) begin
                  state_nxt.level = state.level + 2'd1;
                  changed         = 1'b1;
               end
            end else if (state.level != LEVEL_LOW) begin
               state_nxt.level = state.level - 2'd1;
               changed         = 1'b1;
            end
            state_nxt.up_pending   = 1'b0;
            state_nxt.down_pending = 1'b0;
         end
      end

      result.level              = state_nxt.level;
      result.domain_max_request = state_nxt.domain_req;
      result.bus_max_request    = state_nxt.bus_req;
      result.cpu_forced_max     = state_nxt.force_flag;
      result.level_changed      = changed;
      result.cpu_released       = released;
   end

endmodule

`default_nettype wire

// ===== hw/rtl/utilization_dvfs_governor_top.sv =====
// top level of the three-level utilization dvfs governor
// depends on dvg_pkg and dvg_core
//
// usage
//  - req channel: one beat is a utilization sample (opcode 0) or a
//    millisecond tick (opcode 1); utilization is ignored on ticks
//  - rsp channel: exactly one beat per req beat, in order, carrying the
//    level after the beat, the domain and bus requests, the force flag
//    and the step / release strobes of a tick
//  - csr port: csr_we writes csr_wdata into register csr_index; indexes
//    beyond the list are dropped; write only while the block is idle
//  - latency: the rsp beat is valid in the cycle after the req beat
//  - throughput: one beat per cycle while rsp is not stalled; the whole
//    update is a single pass of compares and one counter decrement
//    between the governor state registers and the rsp register
//  - stall: req_ready stays high while the rsp register is empty or is
//    being taken in the same cycle; a stalled rsp holds its payload
//  - reset: level low, nothing pending, counter and requests clear,
//    registers back to their defaults, no rsp beat pending
`default_nettype none

module utilization_dvfs_governor_top #(
   parameter int DELAY_WIDTH = 16
) (
   input  var logic clock,
   input  var logic reset,

   input  var logic req_valid,
   output logic     req_ready,
   input  var logic req_opcode,
   input  var logic [dvg_pkg::UTIL_WIDTH-1:0] req_utilization,

   output logic       rsp_valid,
   input  var logic   rsp_ready,
   output logic [1:0] rsp_level,
   output logic       rsp_domain_max_request,
   output logic       rsp_bus_max_request,
   output logic       rsp_cpu_forced_max,
   output logic       rsp_level_changed,
   output logic       rsp_cpu_released,

   input  var logic csr_we,
   input  var logic [dvg_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  var logic [dvg_pkg::CSR_DATA_WIDTH-1:0]  csr_wdata
);
   import dvg_pkg::*;

   // configuration registers
   cfg_type                cfg_ff;
   logic [DELAY_WIDTH-1:0] step_delay_ff;

   // governor state
   state_type              state_ff;
   state_type              state_in;
   logic [DELAY_WIDTH-1:0] count_ff;
   logic [DELAY_WIDTH-1:0] count_in;

   // result register
   logic       rsp_valid_ff;
   result_type rsp_ff;
   result_type result;

   logic req_fire;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_fire  = req_valid && req_ready;

   // csr writes, delay register kept to the counter width
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.up_to_high1   <= RST_UP_TO_HIGH1;
         cfg_ff.up_to_high2   <= RST_UP_TO_HIGH2;
         cfg_ff.down_to_low   <= RST_DOWN_TO_LOW;
         cfg_ff.down_to_high1 <= RST_DOWN_TO_HIGH1;
         cfg_ff.force_enable  <= 1'b1;
         cfg_ff.force_thresh  <= RST_FORCE_THRESH;
         step_delay_ff        <= DELAY_WIDTH'(RST_STEP_DELAY);
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_UP_TO_HIGH1:   cfg_ff.up_to_high1   <= csr_wdata[UTIL_WIDTH-1:0];
            CSR_UP_TO_HIGH2:   cfg_ff.up_to_high2   <= csr_wdata[UTIL_WIDTH-1:0];
            CSR_DOWN_TO_LOW:   cfg_ff.down_to_low   <= csr_wdata[UTIL_WIDTH-1:0];
            CSR_DOWN_TO_HIGH1: cfg_ff.down_to_high1 <= csr_wdata[UTIL_WIDTH-1:0];
            CSR_STEP_DELAY:    step_delay_ff        <= DELAY_WIDTH'(csr_wdata);
            CSR_FORCE_ENABLE:  cfg_ff.force_enable  <= csr_wdata[0];
            CSR_FORCE_THRESH:  cfg_ff.force_thresh  <= csr_wdata[UTIL_WIDTH-1:0];
            default: begin
               // unused index, write dropped
            end
         endcase
      end
   end

   dvg_core #(
      .DELAY_WIDTH(DELAY_WIDTH)
   ) u_core (
      .state       (state_ff),
      .count       (count_ff),
      .cfg         (cfg_ff),
      .step_delay  (step_delay_ff),
      .opcode      (req_opcode),
      .utilization (req_utilization),
      .state_nxt   (state_in),
      .count_nxt   (count_in),
      .result      (result)
   );

   // state moves only on an accepted req beat
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
         count_ff <= '0;
      end else if (req_fire) begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_ready) begin
         rsp_valid_ff <= req_valid;
      end
   end

   // payload needs no reset
   always_ff @(posedge clock) begin
      if (req_fire) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_level              = rsp_ff.level;
   assign rsp_domain_max_request = rsp_ff.domain_max_request;
   assign rsp_bus_max_request    = rsp_ff.bus_max_request;
   assign rsp_cpu_forced_max     = rsp_ff.cpu_forced_max;
   assign rsp_level_changed      = rsp_ff.level_changed;
   assign rsp_cpu_released       = rsp_ff.cpu_released;

endmodule

`default_nettype wire

// ===== hw/rtl/dvg_checker.sv =====
// port-level checks for the governor top level, attached by bind
// depends on dvg_pkg and utilization_dvfs_governor_top
`default_nettype none

module dvg_checker (
   input var logic clock,
   input var logic reset,
   input var logic req_valid,
   input var logic req_ready,
   input var logic rsp_valid,
   input var logic rsp_ready,
   input var logic [1:0] rsp_level,
   input var logic rsp_domain_max_request,
   input var logic rsp_bus_max_request,
   input var logic rsp_cpu_forced_max,
   input var logic rsp_cpu_released
);
   import dvg_pkg::*;

   // a reset leaves no rsp beat behind
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp beat pending after reset");

   // every accepted req beat shows up on rsp in the cycle after
   a_one_cycle: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> rsp_valid)
      else $error("rsp beat missing after req beat");

   // the input only stalls behind a stalled rsp beat
   a_no_idle_stall: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !rsp_ready)
      else $error("req stalled while rsp side free");

   // bus request only ever comes with the domain request
   a_bus_implies_domain: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_bus_max_request |-> rsp_domain_max_request)
      else $error("bus request without domain request");

   // a release leaves the force flag clear
   a_release_clears: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_cpu_released |-> !rsp_cpu_forced_max && rsp_level != 2'd3)
      else $error("force flag still set on release");

endmodule

bind utilization_dvfs_governor_top dvg_checker u_dvg_checker (
   .clock                  (clock),
   .reset                  (reset),
   .req_valid              (req_valid),
   .req_ready              (req_ready),
   .rsp_valid              (rsp_valid),
   .rsp_ready              (rsp_ready),
   .rsp_level              (rsp_level),
   .rsp_domain_max_request (rsp_domain_max_request),
   .rsp_bus_max_request    (rsp_bus_max_request),
   .rsp_cpu_forced_max     (rsp_cpu_forced_max),
   .rsp_cpu_released       (rsp_cpu_released)
);

`default_nettype wire
